/* hw/rtl/spq_pkg.sv */
// Shared types and codes for the sorted point queue with prune.
// No dependencies; used by every module of the block.
`default_nettype none

package spq_pkg;

    // Fixed width of every coordinate field on the ports
    localparam int FIELD_BITS = 16;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_COORD_BITS = 16;

    // Opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PRUNE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY_POP = 2'd3;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [FIELD_BITS-1:0] point_x;
        logic [FIELD_BITS-1:0] point_y;
        logic [FIELD_BITS-1:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic                  front_valid;
        logic [FIELD_BITS-1:0] front_x;
        logic [FIELD_BITS-1:0] front_y;
        logic [FIELD_BITS-1:0] front_z;
        logic [6:0]            entry_count;
        logic [5:0]            pruned_count;
    } t_out_item;

endpackage

`default_nettype wire

/* hw/rtl/sorted_point_queue_prune_unit.sv */
// Sorted point queue with prune. Insert scans the list, shifts up from the insert point
// and reads the front; a duplicate or full insert skips the shift; pop and prune walk the
// list, clear does not; each item ends with a front read. The store has a single read
// port, one entry a cycle. One item at a time; the next item is taken while a result
// waits in the output register. Reset empties the list at once; store contents are kept.
`default_nettype none

module sorted_point_queue_prune_unit #(
    parameter int CAPACITY   = spq_pkg::DEF_CAPACITY,
    parameter int COORD_BITS = spq_pkg::DEF_COORD_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire spq_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output spq_pkg::t_out_item     o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int CB = COORD_BITS;
    localparam int PW = 3 * CB;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_PRUNE = 3'd4;
    localparam logic [2:0] S_FRONT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_pt, n_pt;
    logic [PW-1:0] r_keep, n_keep;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_didx, n_didx;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_pruned, n_pruned;
    logic          r_rd_v, n_rd_v;
    logic          r_found, n_found;
    logic          r_dup, n_dup;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    spq_pkg::t_out_item r_out, n_out;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [PW-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0] idx_m1, didx_p1, didx_m1;
    logic [CB-1:0] px, py, pz, qx, qy, qz, kx, ky, kz;
    logic          q_less, q_equal, q_prune, done;

    spq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Field views of the held point, the read entry and the last kept point
    assign px = r_pt[PW-1:2*CB];
    assign py = r_pt[2*CB-1:CB];
    assign pz = r_pt[CB-1:0];
    assign qx = ram_rdata[PW-1:2*CB];
    assign qy = ram_rdata[2*CB-1:CB];
    assign qz = ram_rdata[CB-1:0];
    assign kx = r_keep[PW-1:2*CB];
    assign ky = r_keep[2*CB-1:CB];
    assign kz = r_keep[CB-1:0];

    // Order is x, then z, then y
    assign q_less  = (px < qx) || ((px == qx) && (pz < qz))
                   || ((px == qx) && (pz == qz) && (py < qy));
    assign q_equal = (px == qx) && (py == qy) && (pz == qz);
    assign q_prune = ((kx == qx) && (kz == qz))
                   || ((kx < qx) && (ky == qy) && (kz == qz));

    assign idx_m1  = r_idx - 1'b1;
    assign didx_p1 = r_didx + 1'b1;
    assign didx_m1 = r_didx - 1'b1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer: one store entry read per cycle, processed the cycle after
    always_comb begin
        n_state     = r_state;
        n_pt        = r_pt;
        n_keep      = r_keep;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_didx      = r_didx;
        n_pos       = r_pos;
        n_w         = r_w;
        n_pruned    = r_pruned;
        n_rd_v      = 1'b0;
        n_found     = r_found;
        n_dup       = r_dup;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_pt;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        done        = 1'b0;

        // Result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pt     = {CB'(i_in.point_x), CB'(i_in.point_y), CB'(i_in.point_z)};
                    n_status = spq_pkg::ST_DONE;
                    n_pruned = '0;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_dup    = 1'b0;
                    n_pos    = r_cnt;
                    n_w      = CW'(1);
                    case (i_in.opcode)
                        spq_pkg::OP_INSERT: n_state = S_SCAN;
                        spq_pkg::OP_POP: begin
                            if (r_cnt == '0) begin
                                n_status = spq_pkg::ST_EMPTY_POP;
                                n_state  = S_FRONT;
                            end else begin
                                n_idx   = CW'(1);
                                n_state = S_POP;
                            end
                        end
                        spq_pkg::OP_PRUNE: begin
                            n_state = (r_cnt == '0) ? S_FRONT : S_PRUNE;
                        end
                        default: begin
                            n_cnt   = '0;
                            n_state = S_FRONT;
                        end
                    endcase
                end
            end

            // Duplicate check and insert position, front to back
            S_SCAN: begin
                ram_re    = (r_idx < r_cnt);
                ram_raddr = r_idx[AW-1:0];
                if (ram_re) begin
                    n_idx = r_idx + 1'b1;
                end
                n_rd_v = ram_re;
                n_didx = r_idx;
                if (r_rd_v) begin
                    if (q_equal) begin
                        n_dup = 1'b1;
                    end
                    if (!r_found && q_less) begin
                        n_found = 1'b1;
                        n_pos   = r_didx;
                    end
                end
                if (!ram_re && !r_rd_v) begin
                    if (r_dup) begin
                        n_status = spq_pkg::ST_DUPLICATE;
                        n_state  = S_FRONT;
                    end else if (32'(r_cnt) >= CAPACITY) begin
                        n_status = spq_pkg::ST_FULL;
                        n_state  = S_FRONT;
                    end else begin
                        n_idx   = r_cnt;
                        n_state = S_SHIFT;
                    end
                end
            end

            // Move entries at and above the position up by one, back to front
            S_SHIFT: begin
                ram_re    = (r_idx > r_pos);
                ram_raddr = idx_m1[AW-1:0];
                if (ram_re) begin
                    n_idx = idx_m1;
                end
                n_rd_v = ram_re;
                n_didx = idx_m1;
                if (r_rd_v) begin
                    ram_we    = 1'b1;
                    ram_waddr = didx_p1[AW-1:0];
                    ram_wdata = ram_rdata;
                end else if (!ram_re) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[AW-1:0];
                    ram_wdata = r_pt;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = S_FRONT;
                end
            end

            // Move every entry behind the front down by one
            S_POP: begin
                ram_re    = (r_idx < r_cnt);
                ram_raddr = r_idx[AW-1:0];
                if (ram_re) begin
                    n_idx = r_idx + 1'b1;
                end
                n_rd_v = ram_re;
                n_didx = r_idx;
                if (r_rd_v) begin
                    ram_we    = 1'b1;
                    ram_waddr = didx_m1[AW-1:0];
                    ram_wdata = ram_rdata;
                end else if (!ram_re) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_FRONT;
                end
            end

            // Compact in place against the last kept point
            S_PRUNE: begin
                ram_re    = (r_idx < r_cnt);
                ram_raddr = r_idx[AW-1:0];
                if (ram_re) begin
                    n_idx = r_idx + 1'b1;
                end
                n_rd_v = ram_re;
                n_didx = r_idx;
                if (r_rd_v) begin
                    if (r_didx == '0) begin
                        n_keep = ram_rdata;
                    end else if (q_prune) begin
                        n_pruned = r_pruned + 1'b1;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_w[AW-1:0];
                        ram_wdata = ram_rdata;
                        n_w       = r_w + 1'b1;
                        n_keep    = ram_rdata;
                    end
                end else if (!ram_re) begin
                    n_cnt   = r_w;
                    n_state = S_FRONT;
                end
            end

            // Fetch the front entry
            S_FRONT: begin
                ram_re    = (r_cnt != '0);
                ram_raddr = '0;
                n_state   = S_OUT;
            end

            // Load the result once the output register is free
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    done = 1'b1;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (done) begin
            n_out_valid         = 1'b1;
            n_out.status        = r_status;
            n_out.front_valid   = (r_cnt != '0);
            n_out.front_x       = (r_cnt != '0) ? spq_pkg::FIELD_BITS'(qx) : '0;
            n_out.front_y       = (r_cnt != '0) ? spq_pkg::FIELD_BITS'(qy) : '0;
            n_out.front_z       = (r_cnt != '0) ? spq_pkg::FIELD_BITS'(qz) : '0;
            n_out.entry_count   = (32'(r_cnt) > 32'd127) ? 7'd127 : 7'(r_cnt);
            n_out.pruned_count  = (32'(r_pruned) > 32'd63) ? 6'd63 : 6'(r_pruned);
            n_state             = S_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_v      <= n_rd_v;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        r_pt     <= n_pt;
        r_keep   <= n_keep;
        r_idx    <= n_idx;
        r_didx   <= n_didx;
        r_pos    <= n_pos;
        r_w      <= n_w;
        r_pruned <= n_pruned;
        r_found  <= n_found;
        r_dup    <= n_dup;
        r_status <= n_status;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    // Count never exceeds the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= CAPACITY)
        else $error("entry count above capacity");

    // No read and write of the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("read and write hit the same entry");

    // An accepted item starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted item did not start");

    // A held result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

/* hw/rtl/spq_ram.sv */
// Point store: one write port, one read port, registered read data.
// Standalone; instantiated by sorted_point_queue_prune_unit.
`default_nettype none

module spq_ram #(
    parameter int DEPTH = spq_pkg::DEF_CAPACITY,
    parameter int WIDTH = 3 * spq_pkg::DEF_COORD_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
